// ----- src/hde_pkg.sv -----
`timescale 1ns / 1ps

package hde_pkg;

  localparam int unsigned DATE_LEN      = 29;
  localparam int unsigned QUEUE_DEPTH_D = 4;

  localparam logic [13:0] YEAR_MIN = 14'd1970;
  localparam logic [13:0] YEAR_MAX = 14'd2099;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_LEN   = 3'd1;
  localparam logic [2:0] ST_BAD_MONTH = 3'd2;
  localparam logic [2:0] ST_BAD_DIGIT = 3'd3;
  localparam logic [2:0] ST_BAD_YEAR  = 3'd4;

  // one parsed date, handed from the parser to the arithmetic side
  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic [2:0]  status;
  } hde_rec_t;

endpackage

// ----- src/hde_front.sv -----
`timescale 1ns / 1ps

module hde_front import hde_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_ch,
  input  logic       in_last,
  input  logic       q_full,
  output logic       q_push,
  output hde_rec_t   q_rec
);

  localparam logic [4:0] POS_DAY0   = 5'd5;
  localparam logic [4:0] POS_DAY1   = 5'd6;
  localparam logic [4:0] POS_MON0   = 5'd8;
  localparam logic [4:0] POS_MON1   = 5'd9;
  localparam logic [4:0] POS_MON2   = 5'd10;
  localparam logic [4:0] POS_YEAR0  = 5'd12;
  localparam logic [4:0] POS_YEAR1  = 5'd13;
  localparam logic [4:0] POS_YEAR2  = 5'd14;
  localparam logic [4:0] POS_YEAR3  = 5'd15;
  localparam logic [4:0] POS_HOUR0  = 5'd17;
  localparam logic [4:0] POS_HOUR1  = 5'd18;
  localparam logic [4:0] POS_MIN0   = 5'd20;
  localparam logic [4:0] POS_MIN1   = 5'd21;
  localparam logic [4:0] POS_SEC0   = 5'd23;
  localparam logic [4:0] POS_SEC1   = 5'd24;
  localparam logic [4:0] POS_FINAL  = 5'(DATE_LEN - 1);
  localparam logic [4:0] POS_SAT    = 5'd31;

  function automatic logic [3:0] month_of(input logic [7:0] a, input logic [7:0] b,
                                          input logic [7:0] c);
    logic [23:0] nm;
    nm = {a, b, c};
    unique case (nm)
      "Jan": month_of = 4'd1;
      "Feb": month_of = 4'd2;
      "Mar": month_of = 4'd3;
      "Apr": month_of = 4'd4;
      "May": month_of = 4'd5;
      "Jun": month_of = 4'd6;
      "Jul": month_of = 4'd7;
      "Aug": month_of = 4'd8;
      "Sep": month_of = 4'd9;
      "Oct": month_of = 4'd10;
      "Nov": month_of = 4'd11;
      "Dec": month_of = 4'd12;
      default: month_of = 4'd0;
    endcase
  endfunction

  logic [4:0]  pos_r, pos_nxt;
  logic [6:0]  day_r, day_nxt;
  logic [15:0] mlet_r, mlet_nxt;
  logic [3:0]  mon_r, mon_nxt;
  logic [13:0] year_r, year_nxt;
  logic [6:0]  hour_r, hour_nxt;
  logic [6:0]  min_r, min_nxt;
  logic [6:0]  sec_r, sec_nxt;
  logic        derr_r, derr_nxt;

  logic       fire;
  logic       is_dig;
  logic [3:0] dval;
  logic       num_pos;

  assign in_tready = !q_full;
  assign fire      = in_tvalid && in_tready;
  assign is_dig    = (in_ch >= 8'h30) && (in_ch <= 8'h39);
  assign dval      = in_ch[3:0];

  always_comb begin
    day_nxt  = day_r;
    mlet_nxt = mlet_r;
    mon_nxt  = mon_r;
    year_nxt = year_r;
    hour_nxt = hour_r;
    min_nxt  = min_r;
    sec_nxt  = sec_r;
    num_pos  = 1'b1;
    unique case (pos_r)
      POS_DAY0, POS_DAY1:
        if (is_dig) day_nxt = 7'(day_r * 7'd10 + 7'(dval));
      POS_MON0: begin
        mlet_nxt[15:8] = in_ch;
        num_pos = 1'b0;
      end
      POS_MON1: begin
        mlet_nxt[7:0] = in_ch;
        num_pos = 1'b0;
      end
      POS_MON2: begin
        mon_nxt = month_of(mlet_r[15:8], mlet_r[7:0], in_ch);
        num_pos = 1'b0;
      end
      POS_YEAR0, POS_YEAR1, POS_YEAR2, POS_YEAR3:
        if (is_dig) year_nxt = 14'(year_r * 14'd10 + 14'(dval));
      POS_HOUR0, POS_HOUR1:
        if (is_dig) hour_nxt = 7'(hour_r * 7'd10 + 7'(dval));
      POS_MIN0, POS_MIN1:
        if (is_dig) min_nxt = 7'(min_r * 7'd10 + 7'(dval));
      POS_SEC0, POS_SEC1:
        if (is_dig) sec_nxt = 7'(sec_r * 7'd10 + 7'(dval));
      default: num_pos = 1'b0;
    endcase
    derr_nxt = derr_r || (num_pos && !is_dig);
    pos_nxt  = (pos_r == POS_SAT) ? pos_r : 5'(pos_r + 5'd1);
  end

  // result record built from the state including this character
  always_comb begin
    q_rec.year   = year_nxt;
    q_rec.month  = mon_nxt;
    q_rec.day    = day_nxt;
    q_rec.hour   = hour_nxt;
    q_rec.minute = min_nxt;
    q_rec.second = sec_nxt;
    priority if (pos_r != POS_FINAL)                          q_rec.status = ST_BAD_LEN;
    else if (mon_nxt == 4'd0)                                 q_rec.status = ST_BAD_MONTH;
    else if (derr_nxt)                                        q_rec.status = ST_BAD_DIGIT;
    else if (year_nxt < YEAR_MIN || year_nxt > YEAR_MAX)      q_rec.status = ST_BAD_YEAR;
    else                                                      q_rec.status = ST_OK;
  end

  assign q_push = fire && in_last;

  always_ff @(posedge clk) begin
    if (!rst_n || q_push) begin
      pos_r  <= '0;
      day_r  <= '0;
      mlet_r <= '0;
      mon_r  <= '0;
      year_r <= '0;
      hour_r <= '0;
      min_r  <= '0;
      sec_r  <= '0;
      derr_r <= 1'b0;
    end else if (fire) begin
      pos_r  <= pos_nxt;
      day_r  <= day_nxt;
      mlet_r <= mlet_nxt;
      mon_r  <= mon_nxt;
      year_r <= year_nxt;
      hour_r <= hour_nxt;
      min_r  <= min_nxt;
      sec_r  <= sec_nxt;
      derr_r <= derr_nxt;
    end
  end

endmodule

// ----- src/hde_queue.sv -----
`timescale 1ns / 1ps

module hde_queue import hde_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_D
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  hde_rec_t push_rec,
  output logic     full,
  input  logic     pop,
  output logic     pop_valid,
  output hde_rec_t pop_rec
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  hde_rec_t        mem [DEPTH];
  logic [PW-1:0]   wr_r, rd_r;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full      = (cnt_r == CNT_FULL);
  assign pop_valid = (cnt_r != '0);
  assign pop_rec   = mem[rd_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = CW'(cnt_r + 1'b1);
    else if (do_pop && !do_push) cnt_nxt = CW'(cnt_r - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) wr_r <= (wr_r == PTR_LAST) ? '0 : PW'(wr_r + 1'b1);
      if (do_pop)  rd_r <= (rd_r == PTR_LAST) ? '0 : PW'(rd_r + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_r] <= push_rec;
  end

endmodule

// ----- src/hde_back.sv -----
`timescale 1ns / 1ps

module hde_back import hde_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  hde_rec_t    q_rec,
  output logic        q_pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_epoch,
  output logic [2:0]  out_status
);

  function automatic logic [8:0] days_before(input logic [3:0] idx, input logic leap);
    logic [8:0] d;
    unique case (idx)
      4'd0:  d = 9'd0;
      4'd1:  d = 9'd31;
      4'd2:  d = 9'd59;
      4'd3:  d = 9'd90;
      4'd4:  d = 9'd120;
      4'd5:  d = 9'd151;
      4'd6:  d = 9'd181;
      4'd7:  d = 9'd212;
      4'd8:  d = 9'd243;
      4'd9:  d = 9'd273;
      4'd10: d = 9'd304;
      4'd11: d = 9'd334;
      default: d = 9'd365;
    endcase
    if (leap && idx >= 4'd2) d = 9'(d + 9'd1);
    days_before = d;
  endfunction

  // stage 1: day count (17-bit two's complement) and time of day
  logic               s1_v_r;
  logic signed [16:0] s1_days_r;
  logic [19:0]        s1_tod_r;
  logic [2:0]         s1_st_r;
  logic               out_v_r;
  logic [31:0]        out_epoch_r;
  logic [2:0]         out_st_r;

  logic               out_ld, s1_ld;
  logic               ok;
  logic [7:0]         yoff;
  logic               leap;
  logic [3:0]         midx;
  logic [16:0]        days_c;
  logic [19:0]        tod_c;
  logic [31:0]        epoch_c;

  assign out_ld = !out_v_r || out_tready;
  assign s1_ld  = !s1_v_r || out_ld;
  assign q_pop  = q_valid && s1_ld;

  assign ok   = (q_rec.status == ST_OK);
  assign yoff = 8'(q_rec.year - YEAR_MIN);
  // years 1970..2099 only: every fourth year is leap, 2000 included
  assign leap = (q_rec.year[1:0] == 2'd0);
  assign midx = 4'(q_rec.month - 4'd1);

  // leap days before this year reduce to (yoff + 1) / 4 over this range
  assign days_c = 17'(17'(yoff) * 17'd365 + 17'(9'(yoff + 8'd1) >> 2)
                + 17'(days_before(midx, leap)) + 17'(q_rec.day) - 17'd1);
  assign tod_c  = 20'(20'(q_rec.hour) * 20'd3600 + 20'(q_rec.minute) * 20'd60
                + 20'(q_rec.second));

  assign epoch_c = 32'({{15{s1_days_r[16]}}, s1_days_r} * 32'd86400) + 32'(s1_tod_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_ld)  s1_v_r  <= q_valid;
      if (out_ld) out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_days_r <= ok ? signed'(days_c) : '0;
      s1_tod_r  <= ok ? tod_c : '0;
      s1_st_r   <= q_rec.status;
    end
    if (out_ld && s1_v_r) begin
      out_epoch_r <= epoch_c;
      out_st_r    <= s1_st_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_epoch  = out_epoch_r;
  assign out_status = out_st_r;

endmodule

// ----- src/http_date_to_epoch_seconds.sv -----
`timescale 1ns / 1ps

// HTTP date parser: takes one character of a date such as
// "Sat, 08 Dec 2018 07:38:17 GMT" per cycle, tlast on the final one, and
// returns POSIX seconds plus a status for each string (0 ok, 1 length not
// 29, 2 unknown month, 3 non-digit in a number field, 4 year outside
// 1970..2099; seconds read zero on error). One character is taken per
// cycle while the queue is not full; in_tready drops when it is full.
// A result passes from the parser through the queue into the day-count
// stage, then through the multiply-by-86400 into the output register. The
// parser keeps taking characters while the output stalls until
// QUEUE_DEPTH finished dates wait in its queue.
module http_date_to_epoch_seconds import hde_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_D
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [31:0] epoch_seconds, [34:32] status, rest zero
);

  hde_rec_t    push_rec, head_rec;
  logic        q_full, q_push, q_pop, q_valid;
  logic [31:0] epoch;
  logic [2:0]  status;

  hde_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_ch     (in_tdata),
    .in_last   (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_rec     (push_rec)
  );

  hde_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_rec  (push_rec),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_rec   (head_rec)
  );

  hde_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_rec      (head_rec),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_epoch  (epoch),
    .out_status (status)
  );

  assign out_tdata = {5'd0, status, epoch};

endmodule

// ----- src/hde_checker.sv -----
`timescale 1ns / 1ps

module hde_checker import hde_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[34:32] != ST_OK |-> out_tdata[31:0] == 32'd0)
    else $error("nonzero seconds on error status");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[34:32] <= ST_BAD_YEAR && out_tdata[39:35] == 5'd0)
    else $error("bad status code or padding");

  // input only stalls behind a full pipeline, so a result must be waiting
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no result waiting");

  // nothing can come out in the cycle after reset is sampled low
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result right after reset");

endmodule

bind http_date_to_epoch_seconds hde_checker u_hde_checker (.*);

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import hde_pkg::*;

  localparam int unsigned POS_MAX      = 31;
  localparam int unsigned YEAR_BIAS    = 1900;
  localparam int unsigned SECS_PER_HR  = 3600;
  localparam int unsigned SECS_PER_DAY = 86400;
  localparam int unsigned SECS_PER_YR  = 31536000;
  localparam int unsigned QUAD_CENT    = 299;
  localparam int unsigned LAT_SLACK    = 8;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned RAND_CHARS   = 240;

  typedef struct {
    logic [31:0] secs;
    logic [2:0]  status;
  } date_result_t;

  function automatic bit [23:0] month_name(int m);
    case (m)
      0:  return "Jan";
      1:  return "Feb";
      2:  return "Mar";
      3:  return "Apr";
      4:  return "May";
      5:  return "Jun";
      6:  return "Jul";
      7:  return "Aug";
      8:  return "Sep";
      9:  return "Oct";
      10: return "Nov";
      default: return "Dec";
    endcase
  endfunction

  function automatic int unsigned days_before(int unsigned idx, bit leap);
    case (idx)
      0:  return 0;
      1:  return 31;
      2:  return leap ? 60 : 59;
      3:  return leap ? 91 : 90;
      4:  return leap ? 121 : 120;
      5:  return leap ? 152 : 151;
      6:  return leap ? 182 : 181;
      7:  return leap ? 213 : 212;
      8:  return leap ? 244 : 243;
      9:  return leap ? 274 : 273;
      10: return leap ? 305 : 304;
      default: return leap ? 335 : 334;
    endcase
  endfunction

  class date_scoreboard;
    date_result_t expected_q[$];
    int unsigned pos, day_v, year_v, hour_v, min_v, sec_v, mon_num;
    bit [7:0] mon_first, mon_second;
    bit digit_bad;
    int unsigned mismatches, checked, strings;
    int unsigned status_count[5];

    function void clear_date();
      pos = 0; day_v = 0; year_v = 0; hour_v = 0; min_v = 0; sec_v = 0;
      mon_num = 0; mon_first = '0; mon_second = '0; digit_bad = 1'b0;
    endfunction

    function int unsigned add_digit(int unsigned acc, bit [7:0] c, int unsigned mask);
      if (c < "0" || c > "9") begin
        digit_bad = 1'b1;
        return acc & mask;
      end
      return (acc * 10 + (c - "0")) & mask;
    endfunction

    function int unsigned seconds_of_date();
      int unsigned ty, days_prior, yday, extra;
      bit leap;
      ty = year_v - YEAR_BIAS;
      leap = (year_v % 4 == 0) && ((year_v % 100 != 0) || (year_v % 400 == 0));
      days_prior = days_before((mon_num - 1) % 12, leap);
      yday = days_prior + day_v - 1;
      extra = (ty - 69) / 4 - (ty - 1) / 100 + (ty + QUAD_CENT) / 400;
      return sec_v + min_v * 60 + hour_v * SECS_PER_HR + yday * SECS_PER_DAY
             + (ty - 70) * SECS_PER_YR + extra * SECS_PER_DAY;
    endfunction

    function void note_char(bit [7:0] c, bit last_flag);
      int unsigned p;
      date_result_t r;
      p = pos;
      case (p)
        5, 6:           day_v = add_digit(day_v, c, 'h7F);
        8:              mon_first = c;
        9:              mon_second = c;
        10: begin
          mon_num = 0;
          for (int m = 0; m < 12; m++)
            if (mon_num == 0 && {mon_first, mon_second, c} == month_name(m))
              mon_num = m + 1;
        end
        12, 13, 14, 15: year_v = add_digit(year_v, c, 'h3FFF);
        17, 18:         hour_v = add_digit(hour_v, c, 'h7F);
        20, 21:         min_v = add_digit(min_v, c, 'h7F);
        23, 24:         sec_v = add_digit(sec_v, c, 'h7F);
        default: ;
      endcase
      if (pos < POS_MAX) pos++;
      if (!last_flag) return;
      r.secs = '0;
      if (p != DATE_LEN - 1) r.status = ST_BAD_LEN;
      else if (mon_num == 0) r.status = ST_BAD_MONTH;
      else if (digit_bad) r.status = ST_BAD_DIGIT;
      else if (year_v < YEAR_MIN || year_v > YEAR_MAX) r.status = ST_BAD_YEAR;
      else begin
        r.status = ST_OK;
        r.secs = seconds_of_date();
      end
      expected_q.push_back(r);
      status_count[r.status]++;
      strings++;
      clear_date();
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%t mismatch: %s", $realtime, msg);
    endfunction

    function void check_result(logic [39:0] d);
      date_result_t e;
      checked++;
      if (expected_q.size() == 0) begin
        flag($sformatf("result with none pending: secs %0d status %0d", d[31:0], d[34:32]));
        return;
      end
      e = expected_q.pop_front();
      if (d[31:0] !== e.secs || d[34:32] !== e.status || d[39:35] !== '0)
        flag($sformatf("secs exp %0d got %0d, status exp %0d got %0d, pad %b",
                       e.secs, d[31:0], e.status, d[34:32], d[39:35]));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] ch
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // [31:0] epoch_seconds, [34:32] status, rest zero

  date_scoreboard board = new();
  byte unsigned   date_text[$];
  int             snd_idle_pct = 36;
  int             rcv_idle_pct = 67;
  int unsigned    chars_sent;
  bit             hold_req;
  int unsigned    hold_left;

  http_date_to_epoch_seconds i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata);
  end

  // result side: random backpressure, or a long hold-off on request
  initial begin
    bit hold_taken;
    hold_taken = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        hold_left = HOLD_CYCLES;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  task automatic send_item(input bit [7:0] c, input bit last_flag);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= last_flag;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_char(c, last_flag);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_text();
    for (int i = 0; i < date_text.size(); i++)
      send_item(date_text[i], i == date_text.size() - 1);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (LAT_SLACK) @(negedge clk);
  endtask

  // m is the month index, 0 for January
  task automatic build_date(input int y, input int m, input int d, input int h,
                            input int mi, input int s);
    string days, str;
    int w;
    days = "SunMonTueWedThuFriSat";
    w = $urandom_range(6);
    str = $sformatf("%s, %02d %s %04d %02d:%02d:%02d GMT", days.substr(w * 3, w * 3 + 2),
                    d, month_name(m), y, h, mi, s);
    date_text.delete();
    for (int i = 0; i < str.len(); i++) date_text.push_back(str[i]);
  endtask

  // mostly calendar-sane, sometimes anything two digits hold
  function automatic int field_val(int lo, int hi);
    return ($urandom_range(9) == 0) ? $urandom_range(99) : $urandom_range(hi, lo);
  endfunction

  task automatic send_random_string();
    int kind, n, y;
    kind = $urandom_range(99);
    if (kind < 88) begin
      y = ($urandom_range(9) == 0) ? $urandom_range(9999) : $urandom_range(2099, 1970);
      build_date(y, $urandom_range(11), field_val(1, 31), field_val(0, 23),
                 field_val(0, 59), field_val(0, 59));
      if (kind >= 72) begin
        case ($urandom_range(4))
          0: date_text[$urandom_range(28)] = $urandom_range(255);
          1: date_text.delete($urandom_range(28));
          2: date_text.insert($urandom_range(28), $urandom_range(255));
          3: date_text[8 + $urandom_range(2)] ^= 8'h20;
          default: date_text[$urandom_range(24, 5)] = "x";
        endcase
      end
    end else begin
      n = $urandom_range(40, 1);
      date_text.delete();
      repeat (n) date_text.push_back($urandom_range(255));
    end
    send_text();
  endtask

  initial begin
    int unsigned base;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: range ends, leap rules, every error and odd characters
    build_date(1970, 0, 1, 0, 0, 0);
    date_text[0] = 8'hFF;
    date_text[1] = 8'h00;
    date_text[27] = 8'h80;
    send_text();
    build_date(2099, 11, 31, 23, 59, 59);
    send_text();
    build_date(2000, 1, 29, 12, 0, 0);
    send_text();
    build_date(1970, 0, 0, 0, 0, 0);     // day 00 wraps below zero
    send_text();
    build_date(1969, 11, 31, 23, 59, 59);
    send_text();
    build_date(2100, 0, 1, 0, 0, 0);
    send_text();
    for (int m = 0; m < 12; m++) begin
      build_date(1972 + m * 11, m, (m == 8) ? 99 : 1 + m * 2, (m == 8) ? 99 : m,
                 (m == 8) ? 99 : m * 5, (m == 8) ? 99 : m * 4);
      send_text();
    end
    build_date(2018, 0, 15, 1, 2, 3);
    date_text[8] = "j";                  // month match is case-sensitive
    send_text();
    build_date(2018, 4, 15, 1, 2, 3);
    date_text[13] = "O";
    send_text();
    build_date(2018, 6, 15, 1, 2, 3);
    date_text[6] = 8'h00;
    send_text();
    build_date(2018, 7, 15, 1, 2, 3);
    date_text[9] = "X";
    date_text[20] = "-";
    send_text();
    date_text.delete();
    date_text.push_back("G");
    send_text();
    build_date(2018, 9, 15, 1, 2, 3);
    void'(date_text.pop_back());
    send_text();
    build_date(2018, 10, 15, 1, 2, 3);
    date_text.push_back(" ");
    send_text();
    build_date(2018, 11, 15, 1, 2, 3);
    date_text[10] = "q";
    repeat (11) date_text.push_back("Z"); // position counter saturates
    send_text();
    wait_drained();

    base = chars_sent;
    while (chars_sent < base + RAND_CHARS / 3) send_random_string();
    wait_drained();

    snd_idle_pct = 67;
    rcv_idle_pct = 36;
    while (chars_sent < base + 2 * RAND_CHARS / 3) send_random_string();
    wait_drained();

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    repeat (2) send_random_string();
    hold_req = 1'b1;                     // sink stalls, parser queue must fill
    repeat (7) send_random_string();
    while (chars_sent < base + RAND_CHARS) send_random_string();
    wait_drained();

    $display("covered %0d date strings over %0d characters, %0d results checked",
             board.strings, chars_sent, board.checked);
    $display("status mix: ok %0d, length %0d, month %0d, digit %0d, year %0d",
             board.status_count[ST_OK], board.status_count[ST_BAD_LEN],
             board.status_count[ST_BAD_MONTH], board.status_count[ST_BAD_DIGIT],
             board.status_count[ST_BAD_YEAR]);
    if (board.mismatches == 0 && board.pending() == 0)
      $display("[http_date_to_epoch_seconds] OK");
    else
      $display("[http_date_to_epoch_seconds] ERROR");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout, %0d results still pending", board.pending());
    $display("[http_date_to_epoch_seconds] ERROR");
    $finish;
  end

endmodule
